/* src/double_ended_queue_top_defines.svh */
// Assertion macros for the double-ended queue.
// Included by the checker module; holds nothing but macro definitions.
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define DEQ_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define DEQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

/* src/deq_pkg.sv */
// Shared types and constants of the double-ended queue.
// Used by the cell, the top level and the checker; depends on nothing.
package deq_pkg;

  // Default sizes of the block.
  localparam int CAPACITY_DEF  = 64;
  localparam int ITEM_BITS_DEF = 64;

  // Fixed field widths of the item channels.
  localparam int CMD_W  = 3;
  localparam int POS_W  = 6;
  localparam int DATA_W = 64;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int ETYPE_W = 2;
  localparam logic REG_ELEM_TYPE = 1'b0;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;

  // Element kinds.
  localparam logic [ETYPE_W-1:0] ETYPE_INT32    = 2'd0;
  localparam logic [ETYPE_W-1:0] ETYPE_FLOAT32  = 2'd1;
  localparam logic [ETYPE_W-1:0] ETYPE_DOUBLE64 = 2'd2;
  localparam logic [ETYPE_W-1:0] ETYPE_CHAR8    = 2'd3;

  // What every cell does with its stored word in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_BACK,   // take the word of the front-side neighbor
    CELL_SHIFT_FRONT,  // take the word of the back-side neighbor
    CELL_LOAD_TAIL     // the cell at the current length takes the new item
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
  } cell_ctrl_t;

  // Read token that walks the chain, one cell per cycle.
  typedef struct packed {
    logic             vld;
    logic             hit;
    logic [POS_W-1:0] rem;
  } read_tok_t;

endpackage

/* src/deq_cell.sv */
// One storage cell of the deque chain: a stored word and one read token stage.
// Depends on deq_pkg.
module deq_cell #(
  parameter int ITEM_BITS = deq_pkg::ITEM_BITS_DEF,
  parameter int CNT_W     = 7,
  parameter int IDX       = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  deq_pkg::cell_ctrl_t   ctrl_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [ITEM_BITS-1:0]  item_i,
  input  logic [ITEM_BITS-1:0]  front_word_i,
  input  logic [ITEM_BITS-1:0]  back_word_i,
  output logic [ITEM_BITS-1:0]  word_o,
  input  deq_pkg::read_tok_t    tok_i,
  input  logic [ITEM_BITS-1:0]  tok_data_i,
  output deq_pkg::read_tok_t    tok_o,
  output logic [ITEM_BITS-1:0]  tok_data_o
);

  logic [ITEM_BITS-1:0] word_q, word_d;
  deq_pkg::read_tok_t   tok_q, tok_d;
  logic [ITEM_BITS-1:0] tok_data_q, tok_data_d;
  logic                 hit_here;

  // Stored word: shift with the neighbors or take a new tail item.
  always_comb begin
    word_d = word_q;
    unique case (ctrl_i.op)
      deq_pkg::CELL_HOLD:        word_d = word_q;
      deq_pkg::CELL_SHIFT_BACK:  word_d = front_word_i;
      deq_pkg::CELL_SHIFT_FRONT: word_d = back_word_i;
      deq_pkg::CELL_LOAD_TAIL: begin
        if (count_i == CNT_W'(IDX)) begin
          word_d = item_i;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

  // Read token: the cell whose distance count has run down to zero drops its word in.
  assign hit_here = tok_i.vld && !tok_i.hit && (tok_i.rem == '0);

  always_comb begin
    tok_d      = tok_i;
    tok_data_d = tok_data_i;
    if (hit_here) begin
      tok_d.hit  = 1'b1;
      tok_data_d = word_q;
    end else if (tok_i.vld && !tok_i.hit) begin
      tok_d.rem = tok_i.rem - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_data_q <= tok_data_d;
  end

  assign tok_o      = tok_q;
  assign tok_data_o = tok_data_q;

endmodule

/* src/double_ended_queue_top.sv */
// Top level of the double-ended queue: command decode, length counter,
// configuration register, result register and the chain of deq_cell instances.
// Depends on deq_pkg and deq_cell.
//
// The queue is a row of CAPACITY cells with the front item always in cell 0.
// Push and pop at either end, and every command that fails, act on the row
// and the result together: the whole row shifts by one cell, one cell takes
// the new item, or only the length changes, and the result is registered at
// the same edge. A successful read at a position sends a read token into
// cell 0; it passes one cell per clock down the whole row, picks up the word
// of the addressed cell on the way, and leaves the last cell into the result
// register. No further command is taken while a read token is in the row.
// The store needs no clearing after reset; a new command is taken as soon as
// a finished result has left or is leaving the result register. element_type
// sets how many low bits of a pushed item are kept (32, 32, 64 or 8, and at
// most ITEM_BITS); items already stored keep their bits.
module double_ended_queue_top #(
  parameter int CAPACITY  = deq_pkg::CAPACITY_DEF,
  parameter int ITEM_BITS = deq_pkg::ITEM_BITS_DEF,
  localparam int LEN_W    = $clog2(CAPACITY + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [deq_pkg::PADDR_W-1:0]  paddr,
  input  logic [deq_pkg::PDATA_W-1:0]  pwdata,
  output logic [deq_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  // Command channel.
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [deq_pkg::CMD_W-1:0]    command_i,
  input  logic [deq_pkg::DATA_W-1:0]   item_value_i,
  input  logic [deq_pkg::POS_W-1:0]    position_i,
  // Result channel.
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         success_o,
  output logic [deq_pkg::DATA_W-1:0]   read_data_o,
  output logic [LEN_W-1:0]             current_length_o,
  output logic                         is_empty_o
);

  localparam int CMP_W = (LEN_W > deq_pkg::POS_W) ? LEN_W : deq_pkg::POS_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                          state_q, state_d;
  logic [LEN_W-1:0]              count_q, count_d;
  logic [deq_pkg::ETYPE_W-1:0]   etype_q;
  logic                          cfg_wr;

  logic [deq_pkg::DATA_W-1:0]    elem_mask;
  logic [ITEM_BITS-1:0]          item_trunc;
  logic                          accept;
  logic                          is_full;
  logic                          is_empty_now;
  logic                          in_range;

  deq_pkg::cell_ctrl_t           ctrl;
  deq_pkg::read_tok_t            launch_tok;

  logic [ITEM_BITS-1:0]          words    [CAPACITY];
  deq_pkg::read_tok_t            toks     [CAPACITY+1];
  logic [ITEM_BITS-1:0]          tok_data [CAPACITY+1];

  logic                          res_load;
  logic                          res_ok;
  logic [deq_pkg::DATA_W-1:0]    res_data;
  logic                          out_valid_q, out_valid_d;
  logic                          success_q;
  logic [deq_pkg::DATA_W-1:0]    read_data_q;
  logic [LEN_W-1:0]              length_q;
  logic                          empty_q;

  // Configuration register: one write per completed access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == deq_pkg::REG_ELEM_TYPE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      etype_q <= deq_pkg::ETYPE_INT32;
    end else if (cfg_wr) begin
      etype_q <= pwdata[deq_pkg::ETYPE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == deq_pkg::REG_ELEM_TYPE) ? deq_pkg::PDATA_W'(etype_q) : '0;

  // Keep only the low bits that the element kind and the word width allow.
  always_comb begin
    unique case (etype_q)
      deq_pkg::ETYPE_INT32:    elem_mask = 64'h0000_0000_FFFF_FFFF;
      deq_pkg::ETYPE_FLOAT32:  elem_mask = 64'h0000_0000_FFFF_FFFF;
      deq_pkg::ETYPE_DOUBLE64: elem_mask = 64'hFFFF_FFFF_FFFF_FFFF;
      deq_pkg::ETYPE_CHAR8:    elem_mask = 64'h0000_0000_0000_00FF;
      default:                 elem_mask = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
  end

  assign item_trunc = ITEM_BITS'(item_value_i & elem_mask);

  // Handshake: a new item only when no read is under way and the result slot frees up.
  assign in_ready_o   = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept       = in_valid_i && in_ready_o;
  assign is_full      = (count_q == LEN_W'(CAPACITY));
  assign is_empty_now = (count_q == '0);
  assign in_range     = (CMP_W'(position_i) < CMP_W'(count_q));

  // Command decode and length update.
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ctrl.op    = deq_pkg::CELL_HOLD;
    launch_tok = '0;
    res_load   = 1'b0;
    res_ok     = 1'b0;
    res_data   = '0;
    if (state_q == ST_READ) begin
      if (toks[CAPACITY].vld) begin
        res_load = 1'b1;
        res_ok   = 1'b1;
        res_data = deq_pkg::DATA_W'(tok_data[CAPACITY]);
        state_d  = ST_IDLE;
      end
    end else if (accept) begin
      res_load = 1'b1;
      unique case (command_i)
        deq_pkg::CMD_PUSH_BACK: begin
          if (!is_full) begin
            ctrl.op = deq_pkg::CELL_LOAD_TAIL;
            count_d = count_q + 1'b1;
            res_ok  = 1'b1;
          end
        end
        deq_pkg::CMD_PUSH_FRONT: begin
          if (!is_full) begin
            ctrl.op = deq_pkg::CELL_SHIFT_BACK;
            count_d = count_q + 1'b1;
            res_ok  = 1'b1;
          end
        end
        deq_pkg::CMD_POP_BACK: begin
          if (!is_empty_now) begin
            count_d = count_q - 1'b1;
            res_ok  = 1'b1;
          end
        end
        deq_pkg::CMD_POP_FRONT: begin
          if (!is_empty_now) begin
            ctrl.op = deq_pkg::CELL_SHIFT_FRONT;
            count_d = count_q - 1'b1;
            res_ok  = 1'b1;
          end
        end
        deq_pkg::CMD_READ: begin
          if (in_range) begin
            launch_tok.vld = 1'b1;
            launch_tok.rem = position_i;
            res_load       = 1'b0;
            state_d        = ST_READ;
          end
        end
        default: begin
          res_ok = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Chain of cells; the read token enters at the front cell.
  assign toks[0]     = launch_tok;
  assign tok_data[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ITEM_BITS-1:0] front_word;
    logic [ITEM_BITS-1:0] back_word;

    if (i == 0) begin : g_first
      assign front_word = item_trunc;
    end else begin : g_inner_front
      assign front_word = words[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign back_word = words[i];
    end else begin : g_inner_back
      assign back_word = words[i+1];
    end

    deq_cell #(
      .ITEM_BITS (ITEM_BITS),
      .CNT_W     (LEN_W),
      .IDX       (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .item_i       (item_trunc),
      .front_word_i (front_word),
      .back_word_i  (back_word),
      .word_o       (words[i]),
      .tok_i        (toks[i]),
      .tok_data_i   (tok_data[i]),
      .tok_o        (toks[i+1]),
      .tok_data_o   (tok_data[i+1])
    );
  end

  // Result register between the queue and the result channel.
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      success_q   <= res_ok;
      read_data_q <= res_data;
      length_q    <= count_d;
      empty_q     <= (count_d == '0);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign success_o        = success_q;
  assign read_data_o      = read_data_q;
  assign current_length_o = length_q;
  assign is_empty_o       = empty_q;

endmodule

/* src/deq_checker.sv */
// Port-level checks of the double-ended queue and the bind that attaches them.
// Depends on deq_pkg and double_ended_queue_top_defines.svh.
`include "double_ended_queue_top_defines.svh"

module deq_checker #(
  parameter int CAPACITY = deq_pkg::CAPACITY_DEF,
  localparam int LEN_W   = $clog2(CAPACITY + 1)
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        success_o,
  input logic [deq_pkg::DATA_W-1:0]  read_data_o,
  input logic [LEN_W-1:0]            current_length_o,
  input logic                        is_empty_o
);

  // The empty flag agrees with the reported length.
  `DEQ_ASSERT_NOW(a_empty_len, clk_i, rst_ni, out_valid_o, is_empty_o == (current_length_o == '0))

  // A failed command never returns data.
  `DEQ_ASSERT_NOW(a_fail_no_data, clk_i, rst_ni, out_valid_o && !success_o, read_data_o == '0)

  // The length never exceeds the capacity.
  `DEQ_ASSERT_NOW(a_len_bound, clk_i, rst_ni, out_valid_o, current_length_o <= LEN_W'(CAPACITY))

  // A result that is not taken stays in place.
  `DEQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(read_data_o) && $stable(current_length_o))

endmodule

bind double_ended_queue_top deq_checker #(
  .CAPACITY (CAPACITY)
) u_deq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .success_o        (success_o),
  .read_data_o      (read_data_o),
  .current_length_o (current_length_o),
  .is_empty_o       (is_empty_o)
);
